>>> src/swept_lowpass_highpass_iir_top_defines.svh
// ----------------------------------------------------------------------------
// swept_lowpass_highpass_iir_top_defines.svh
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef SWEPT_LOWPASS_HIGHPASS_IIR_TOP_DEFINES_SVH
`define SWEPT_LOWPASS_HIGHPASS_IIR_TOP_DEFINES_SVH

// clocked assertion, off while reset is active
`define SLHI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion, checked during reset too
`define SLHI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/slhi_pkg.sv
// ----------------------------------------------------------------------------
// slhi_pkg
// types and fixed constants of the swept lowpass/highpass filter
// ----------------------------------------------------------------------------
package slhi_pkg;

  // width of the shared divider datapath
  localparam int DIV_W = 60;
  // shared multiplier operand width
  localparam int MUL_W = 34;
  // numerator register width of the cutoff division
  localparam int NUM_W = 61;

  localparam logic [26:0] TWOPI_Q24     = 27'd105414357;
  localparam logic [25:0] TWO_SQRT2_Q24 = 26'd47453133;
  localparam logic signed [59:0] ONE_Q40 = 60'sd1 <<< 40;

  typedef enum logic [1:0] {
    CFG_FILTER_MODE = 2'd0,
    CFG_SAMPLE_RATE = 2'd1,
    CFG_BLOCK_LEN   = 2'd2
  } cfg_index_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_NUM, ST_XCHK, ST_XDIV,
    ST_M4, ST_M5, ST_COEF, ST_DINIT, ST_DIV, ST_DRND,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_FIN
  } state_e;

  typedef struct packed {
    logic [DIV_W-1:0] t;
    logic [DIV_W-1:0] dd;
  } div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic             qbit;
  } div_rsp_t;

endpackage

>>> src/slhi_div_step.sv
// ----------------------------------------------------------------------------
// slhi_div_step
// one restoring division step: compare and conditional subtract
// ----------------------------------------------------------------------------
module slhi_div_step (
  input  slhi_pkg::div_req_t req_i,
  output slhi_pkg::div_rsp_t rsp_o
);

  logic ge;

  assign ge         = (req_i.t >= req_i.dd);
  assign rsp_o.qbit = ge;
  assign rsp_o.rem  = ge ? (req_i.t - req_i.dd) : req_i.t;

endmodule

>>> src/swept_lowpass_highpass_iir_top.sv
// ----------------------------------------------------------------------------
// swept_lowpass_highpass_iir_top
// swept-cutoff first/second order lowpass and highpass iir filter
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o) moves one beat: a sample and the
//   block's start and end cutoff. output channel (out_valid_o/out_ready_i)
//   moves one filtered sample per input beat, in order.
//   config channel (cfg_valid_i/cfg_ready_o) writes mode, sample rate and
//   block length; it is always ready; the user writes it only while idle, and the block itself does not enforce this.
// datapath:
//   a shared multiplier runs 9 products per beat, and a shared
//   one-bit-per-cycle divider runs 32 steps for the normalized cutoff
//   (skipped when the cutoff saturates) and 33 steps plus a setup and a
//   rounding state for each of the 2 or 3 coefficient divisions. the
//   input is not ready while a beat is at work, so a new beat is taken
//   only once the sequencer has finished the previous one.
// reset:
//   delay lines and block position clear, config returns to mode 2,
//   48 kHz and a block length of 256.
// stall:
//   a finished sample waits in the output register; the next beat is
//   accepted meanwhile, and its result holds in the last step until the
//   register is free.
// ----------------------------------------------------------------------------
module swept_lowpass_highpass_iir_top #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int MAX_BLOCK    = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [16:0]                    cutoff_start_i,
  input  logic [16:0]                    cutoff_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [17:0]                    cfg_data_i
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = $clog2(MAX_BLOCK);
  localparam int GUARD = (32 - SW) / 2;
  localparam int XW    = SW + 2 + GUARD;
  localparam int FW    = 17 + PW;
  localparam int DW    = 18 + PW;
  localparam int MW    = slhi_pkg::MUL_W;
  localparam int PRW   = 2 * MW;
  localparam int RW    = slhi_pkg::DIV_W;
  localparam int NW    = slhi_pkg::NUM_W;
  localparam logic signed [32:0] HALF = 33'((33'd1 << GUARD) >> 1);
  localparam logic signed [32:0] O_HI = (33'sd1 <<< (SW - 1)) - 33'sd1;
  localparam logic signed [32:0] O_LO = -(33'sd1 <<< (SW - 1));
  localparam logic signed [PRW-1:0] Y_HI = PRW'(64'sh7FFF_FFFF);
  localparam logic signed [PRW-1:0] Y_LO = -PRW'(64'sh8000_0000);

  slhi_pkg::state_e state_q, state_d;

  // config registers
  logic [1:0]  mode_q, mode_d;
  logic [17:0] fs_q, fs_d;
  logic [12:0] blen_q, blen_d;

  // filter state
  logic signed [SW-1:0] u1_q, u1_d, u2_q, u2_d;
  logic signed [31:0]   y1_q, y1_d, y2_q, y2_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic                 out_valid_q, out_valid_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [1:0]           dsel_q, dsel_d;

  // per-beat payload
  logic signed [SW-1:0]  u0_q, u0_d;
  logic [16:0]           start_q, start_d, end_q, end_d;
  logic [FW-1:0]         fnum_q, fnum_d;
  logic [DW-1:0]         den_q, den_d;
  logic [NW-1:0]         nreg_q, nreg_d;
  logic [RW-1:0]         r_q, r_d;
  logic [32:0]           q_q, q_d;
  logic signed [59:0]    s_q, s_d, a_q, a_d, b_q, b_d, c_q, c_d, k_q, k_d;
  logic                  neg_q, neg_d;
  logic signed [MW-1:0]  g_q, g_d, a1_q, a1_d, a2_q, a2_d;
  logic signed [PRW-1:0] acc_q, acc_d, prod_q, prod_d;
  logic signed [SW-1:0]  out_q, out_d;

  // shared multiplier
  logic signed [MW-1:0] ma, mb;
  assign prod_d = ma * mb;

  // shared divider step
  slhi_pkg::div_req_t div_req;
  slhi_pkg::div_rsp_t div_rsp;

  slhi_div_step u_div (
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // effective block length and ramp position
  logic [PW:0]   len_c;
  logic [PW-1:0] lm1_c, pos_c;
  logic          second, high;

  always_comb begin
    if (blen_q < 13'd2) begin
      len_c = (PW+1)'(2);
    end else if (32'(blen_q) > MAX_BLOCK) begin
      len_c = (PW+1)'(MAX_BLOCK);
    end else begin
      len_c = (PW+1)'(blen_q);
    end
  end

  assign lm1_c  = PW'(len_c - (PW+1)'(1));
  assign pos_c  = (pos_q > lm1_c) ? lm1_c : pos_q;
  assign second = mode_q[1];
  assign high   = mode_q[0];

  // feed-forward sum with guard bits
  logic signed [XW-1:0] ff_c, xs_c;

  always_comb begin
    if (second) begin
      ff_c = high ? (XW'(u0_q) - (XW'(u1_q) <<< 1) + XW'(u2_q))
                  : (XW'(u0_q) + (XW'(u1_q) <<< 1) + XW'(u2_q));
    end else begin
      ff_c = high ? (XW'(u0_q) - XW'(u1_q)) : (XW'(u0_q) + XW'(u1_q));
    end
    xs_c = ff_c <<< GUARD;
  end

  // polynomial terms from the latest product
  logic signed [59:0] p2_c, xq_c, sel_n;
  assign p2_c = $signed(prod_q[67:8]);
  assign xq_c = $signed(60'({q_q[31:0], 16'd0}));

  always_comb begin
    case (dsel_q)
      2'd0:    sel_n = k_q;
      2'd1:    sel_n = b_q;
      default: sel_n = c_q;
    endcase
  end

  // output rounding and saturation
  logic signed [PRW-1:0] accr_c, yw_c;
  logic signed [31:0]    y_c;
  logic signed [32:0]    ys_c, os_c;
  logic signed [SW-1:0]  o_c;
  logic [33:0]           qr_c;

  always_comb begin
    accr_c = acc_q + (PRW'(1) <<< 27);
    yw_c   = accr_c >>> 28;
    if (yw_c > Y_HI) begin
      y_c = 32'sh7FFF_FFFF;
    end else if (yw_c < Y_LO) begin
      y_c = 32'sh8000_0000;
    end else begin
      y_c = yw_c[31:0];
    end
    ys_c = 33'(y_c) + HALF;
    os_c = ys_c >>> GUARD;
    if (os_c > O_HI) begin
      o_c = O_HI[SW-1:0];
    end else if (os_c < O_LO) begin
      o_c = O_LO[SW-1:0];
    end else begin
      o_c = os_c[SW-1:0];
    end
    qr_c = ({1'b0, q_q} + 34'd1) >> 1;
  end

  assign in_ready_o   = (state_q == slhi_pkg::ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    fs_d        = fs_q;
    blen_d      = blen_q;
    u0_d        = u0_q;
    u1_d        = u1_q;
    u2_d        = u2_q;
    y1_d        = y1_q;
    y2_d        = y2_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_d       = cnt_q;
    dsel_d      = dsel_q;
    start_d     = start_q;
    end_d       = end_q;
    fnum_d      = fnum_q;
    den_d       = den_q;
    nreg_d      = nreg_q;
    r_d         = r_q;
    q_d         = q_q;
    s_d         = s_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    k_d         = k_q;
    neg_d       = neg_q;
    g_d         = g_q;
    a1_d        = a1_q;
    a2_d        = a2_q;
    acc_d       = acc_q;
    out_d       = out_q;
    ma          = '0;
    mb          = '0;
    div_req.t   = r_q;
    div_req.dd  = a_q;

    // config beat
    if (cfg_valid_i) begin
      case (cfg_index_i)
        slhi_pkg::CFG_FILTER_MODE: mode_d = cfg_data_i[1:0];
        slhi_pkg::CFG_SAMPLE_RATE: fs_d   = cfg_data_i;
        slhi_pkg::CFG_BLOCK_LEN:   blen_d = cfg_data_i[12:0];
        default: ;
      endcase
    end

    case (state_q)
      slhi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          u0_d    = sample_in_i;
          start_d = cutoff_start_i;
          end_d   = cutoff_end_i;
          state_d = slhi_pkg::ST_M0;
        end
      end
      slhi_pkg::ST_M0: begin
        ma      = MW'(start_q);
        mb      = MW'(lm1_c - pos_c);
        state_d = slhi_pkg::ST_M1;
      end
      slhi_pkg::ST_M1: begin
        fnum_d  = prod_q[FW-1:0];
        ma      = MW'(end_q);
        mb      = MW'(pos_c);
        state_d = slhi_pkg::ST_M2;
      end
      slhi_pkg::ST_M2: begin
        fnum_d  = fnum_q + prod_q[FW-1:0];
        ma      = MW'(lm1_c);
        mb      = MW'(fs_q);
        state_d = slhi_pkg::ST_M3;
      end
      slhi_pkg::ST_M3: begin
        den_d   = prod_q[DW-1:0];
        ma      = MW'(fnum_q);
        mb      = MW'(slhi_pkg::TWOPI_Q24);
        state_d = slhi_pkg::ST_NUM;
      end
      slhi_pkg::ST_NUM: begin
        // rounded numerator of the cutoff division
        nreg_d  = prod_q[NW-1:0] + NW'(den_q >> 1);
        state_d = slhi_pkg::ST_XCHK;
      end
      slhi_pkg::ST_XCHK: begin
        // zero rate or quotient past 32 bits saturates
        if ((den_q == '0) || (RW'(nreg_q[NW-1:32]) >= RW'(den_q))) begin
          q_d     = 33'(32'hFFFF_FFFF);
          state_d = slhi_pkg::ST_M4;
        end else begin
          r_d     = RW'(nreg_q[NW-1:32]);
          q_d     = '0;
          cnt_d   = '0;
          state_d = slhi_pkg::ST_XDIV;
        end
      end
      slhi_pkg::ST_XDIV: begin
        div_req.t  = {r_q[RW-2:0], nreg_q[31]};
        div_req.dd = RW'(den_q);
        r_d        = div_rsp.rem;
        q_d        = {q_q[31:0], div_rsp.qbit};
        nreg_d     = nreg_q << 1;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = slhi_pkg::ST_M4;
        end
      end
      slhi_pkg::ST_M4: begin
        ma      = MW'(q_q[31:0]);
        mb      = MW'(slhi_pkg::TWO_SQRT2_Q24);
        state_d = slhi_pkg::ST_M5;
      end
      slhi_pkg::ST_M5: begin
        s_d     = $signed(prod_q[67:8]);
        ma      = MW'(q_q[31:0]);
        mb      = MW'(q_q[31:0]);
        state_d = slhi_pkg::ST_COEF;
      end
      slhi_pkg::ST_COEF: begin
        if (second) begin
          a_d = (slhi_pkg::ONE_Q40 <<< 2) + s_q + p2_c;
          b_d = (p2_c <<< 1) - (slhi_pkg::ONE_Q40 <<< 3);
          c_d = (slhi_pkg::ONE_Q40 <<< 2) - s_q + p2_c;
          k_d = high ? (slhi_pkg::ONE_Q40 <<< 2) : p2_c;
        end else begin
          a_d = xq_c + (slhi_pkg::ONE_Q40 <<< 1);
          b_d = xq_c - (slhi_pkg::ONE_Q40 <<< 1);
          c_d = '0;
          k_d = high ? (slhi_pkg::ONE_Q40 <<< 1) : xq_c;
        end
        a2_d    = '0;
        dsel_d  = '0;
        state_d = slhi_pkg::ST_DINIT;
      end
      slhi_pkg::ST_DINIT: begin
        neg_d   = sel_n[59];
        r_d     = sel_n[59] ? RW'(-sel_n) : RW'(sel_n);
        q_d     = '0;
        cnt_d   = '0;
        state_d = slhi_pkg::ST_DIV;
      end
      slhi_pkg::ST_DIV: begin
        // two integer bits against 2a then a, then fraction bits
        div_req.t  = (cnt_q >= 6'd2) ? {r_q[RW-2:0], 1'b0} : r_q;
        div_req.dd = (cnt_q == 6'd0) ? {a_q[RW-2:0], 1'b0} : a_q;
        r_d        = div_rsp.rem;
        q_d        = {q_q[31:0], div_rsp.qbit};
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          state_d = slhi_pkg::ST_DRND;
        end
      end
      slhi_pkg::ST_DRND: begin
        case (dsel_q)
          2'd0:    g_d  = neg_q ? -$signed(qr_c) : $signed(qr_c);
          2'd1:    a1_d = neg_q ? -$signed(qr_c) : $signed(qr_c);
          default: a2_d = neg_q ? -$signed(qr_c) : $signed(qr_c);
        endcase
        if (dsel_q == (second ? 2'd2 : 2'd1)) begin
          state_d = slhi_pkg::ST_F0;
        end else begin
          dsel_d  = dsel_q + 2'd1;
          state_d = slhi_pkg::ST_DINIT;
        end
      end
      slhi_pkg::ST_F0: begin
        ma      = g_q;
        mb      = MW'(xs_c);
        state_d = slhi_pkg::ST_F1;
      end
      slhi_pkg::ST_F1: begin
        acc_d   = prod_q >>> 2;
        ma      = a1_q;
        mb      = MW'(y1_q);
        state_d = slhi_pkg::ST_F2;
      end
      slhi_pkg::ST_F2: begin
        acc_d   = acc_q - (prod_q >>> 2);
        ma      = a2_q;
        mb      = MW'(y2_q);
        state_d = slhi_pkg::ST_F3;
      end
      slhi_pkg::ST_F3: begin
        acc_d   = acc_q - (prod_q >>> 2);
        state_d = slhi_pkg::ST_FIN;
      end
      slhi_pkg::ST_FIN: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          out_d       = o_c;
          out_valid_d = 1'b1;
          u2_d        = u1_q;
          u1_d        = u0_q;
          y2_d        = y1_q;
          y1_d        = y_c;
          pos_d       = (pos_c >= lm1_c) ? '0 : pos_c + PW'(1);
          state_d     = slhi_pkg::ST_IDLE;
        end
      end
      default: state_d = slhi_pkg::ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slhi_pkg::ST_IDLE;
      mode_q      <= 2'd2;
      fs_q        <= 18'd48000;
      blen_q      <= 13'd256;
      u1_q        <= '0;
      u2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dsel_q      <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fs_q        <= fs_d;
      blen_q      <= blen_d;
      u1_q        <= u1_d;
      u2_q        <= u2_d;
      y1_q        <= y1_d;
      y2_q        <= y2_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      dsel_q      <= dsel_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    u0_q    <= u0_d;
    start_q <= start_d;
    end_q   <= end_d;
    fnum_q  <= fnum_d;
    den_q   <= den_d;
    nreg_q  <= nreg_d;
    r_q     <= r_d;
    q_q     <= q_d;
    s_q     <= s_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    k_q     <= k_d;
    neg_q   <= neg_d;
    g_q     <= g_d;
    a1_q    <= a1_d;
    a2_q    <= a2_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

endmodule

>>> src/slhi_checker.sv
// ----------------------------------------------------------------------------
// slhi_checker
// port-level checks of the swept filter, bound to the top level
// ----------------------------------------------------------------------------
`include "swept_lowpass_highpass_iir_top_defines.svh"

module slhi_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                    cfg_ready_o
);

  // a beat in work blocks the input
  `SLHI_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "input ready right after a beat")

  // no result can appear in the cycle after a beat
  `SLHI_ASSERT(a_no_instant_out, (in_valid_i && in_ready_o) |=> !$rose(out_valid_o), "output too early")

  // a stalled result holds
  `SLHI_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_out_o)), "stalled output changed")

  // config port never stalls
  `SLHI_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "config port not ready")

endmodule

bind swept_lowpass_highpass_iir_top slhi_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_slhi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .cfg_ready_o  (cfg_ready_o)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the swept lowpass/highpass iir filter: a queue-fed
// driver, a bit-exact fixed-point predictor and a monitor that checks every
// filtered sample, across modes, sample rates and block lengths
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] MODE_LP1 = 2'd0;
  localparam logic [1:0] MODE_HP1 = 2'd1;
  localparam logic [1:0] MODE_LP2 = 2'd2;
  localparam logic [1:0] MODE_HP2 = 2'd3;
  localparam bit [63:0] X_SAT   = 64'hFFFF_FFFF;
  localparam longint    Q40_ONE = 64'sd1 <<< 40;
  localparam int        WDOG_LIMIT = 5000;
  localparam int        RAND_ITEMS = 480;

  // per-phase config
  localparam logic [1:0] PH_MODE [12] = '{MODE_LP1, MODE_HP1, MODE_LP2, MODE_HP2,
                                          MODE_LP1, MODE_HP1, MODE_LP2, MODE_HP2,
                                          MODE_LP1, MODE_HP2, MODE_LP2, MODE_HP1};
  localparam logic [17:0] PH_FS [12] = '{18'd48000, 18'd8000, 18'd192000, 18'd0,
                                         18'd262143, 18'd44100, 18'd96000,
                                         18'd48000, 18'd22050, 18'd192000,
                                         18'd8000, 18'd44100};
  localparam logic [12:0] PH_LEN [12] = '{13'd2, 13'd4096, 13'd0, 13'd8191, 13'd1,
                                          13'd16, 13'd3, 13'd100, 13'd5, 13'd2,
                                          13'd7, 13'd4};

  typedef struct packed {
    logic signed [23:0] smp;
    logic [16:0]        f_start;
    logic [16:0]        f_end;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [23:0] sample_in_i = '0;
  logic [16:0] cutoff_start_i = '0;
  logic [16:0] cutoff_end_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [23:0] sample_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;

  swept_lowpass_highpass_iir_top uut (.*);

  // shadow of the block's config and filter state
  logic [1:0]  mode_sh = MODE_LP2;
  bit [17:0]   fs_sh = 18'd48000;
  bit [12:0]   len_sh = 13'd256;
  longint      xd1 = 0, xd2 = 0, yd1 = 0, yd2 = 0;
  bit [63:0]   ramp_pos = 0;

  beat_t pending_beats[$];
  logic signed [23:0] expected_samples[$];
  bit in_fire = 1'b0;
  bit calm = 1'b0;
  int errors = 0;
  int n_in = 0, n_out = 0, n_cfg = 0;
  int idle_cnt = 0;

  initial forever #4 clk_i = ~clk_i;

  // signed Q30 quotient, rounded half away from zero
  function automatic longint q30_div(longint num, longint dv);
    bit [63:0] d, mag, q, r;
    d = dv;
    mag = (num < 0) ? -num : num;
    q = mag / d;
    r = mag % d;
    for (int i = 0; i < 31; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    q = (q + 64'd1) >> 1;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one filter step: swept cutoff, bilinear coefficients, recursion
  function automatic logic signed [23:0] filter_step(beat_t b);
    longint u0, xq, sq, p2, ca, cb, cc, ck, g, a1, a2, xs, acc, y, o;
    bit [63:0] len, pos, fnum, den, x, fs_w, st, en;
    bit second, high;
    u0 = b.smp;
    second = mode_sh[1];
    high = mode_sh[0];
    len = len_sh;
    if (len < 2) len = 2;
    if (len > 4096) len = 4096;
    pos = ramp_pos;
    if (pos > len - 1) pos = len - 1;
    st = b.f_start;
    en = b.f_end;
    fs_w = fs_sh;
    fnum = st * (len - 1 - pos) + en * pos;
    den = (len - 1) * fs_w;
    if (den == 0) x = X_SAT;
    else begin
      x = (fnum * 64'(slhi_pkg::TWOPI_Q24) + den / 2) / den;
      if (x > X_SAT) x = X_SAT;
    end
    xq = x << 16;
    sq = (x * 64'(slhi_pkg::TWO_SQRT2_Q24)) >> 8;
    p2 = (x * x) >> 8;
    if (second) begin
      ca = 4 * Q40_ONE + sq + p2;
      cb = 2 * p2 - 8 * Q40_ONE;
      cc = 4 * Q40_ONE - sq + p2;
      ck = high ? 4 * Q40_ONE : p2;
      xs = high ? (u0 - 2 * xd1 + xd2) : (u0 + 2 * xd1 + xd2);
    end else begin
      ca = xq + 2 * Q40_ONE;
      cb = xq - 2 * Q40_ONE;
      cc = 0;
      ck = high ? 2 * Q40_ONE : xq;
      xs = high ? (u0 - xd1) : (u0 + xd1);
    end
    g = q30_div(ck, ca);
    a1 = q30_div(cb, ca);
    a2 = second ? q30_div(cc, ca) : 0;
    xs = xs * 16;
    acc = ((g * xs) >>> 2) - ((a1 * yd1) >>> 2) - ((a2 * yd2) >>> 2);
    y = clip((acc + (64'sd1 <<< 27)) >>> 28, 32);
    o = clip((y + 8) >>> 4, 24);
    xd2 = xd1;
    xd1 = u0;
    yd2 = yd1;
    yd1 = y;
    ramp_pos = (pos >= len - 1) ? 0 : pos + 1;
    return o[23:0];
  endfunction

  // driver: next beat at the falling edge once the current one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        beat_t nb;
        nb = pending_beats.pop_front();
        sample_in_i <= nb.smp;
        cutoff_start_i <= nb.f_start;
        cutoff_end_i <= nb.f_end;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 13);
  end

  // monitor: predict on input beats, check on output beats, track config
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        case (slhi_pkg::cfg_index_e'(cfg_index_i))
          slhi_pkg::CFG_FILTER_MODE: mode_sh = cfg_data_i[1:0];
          slhi_pkg::CFG_SAMPLE_RATE: fs_sh = cfg_data_i;
          slhi_pkg::CFG_BLOCK_LEN:   len_sh = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        n_in++;
        expected_samples.push_back(filter_step({sample_in_i, cutoff_start_i, cutoff_end_i}));
      end
      if (out_valid_o && out_ready_i) begin
        n_out++;
        if (expected_samples.size() == 0) begin
          errors++;
          $error("sample_out: unexpected beat, actual %0d", sample_out_o);
        end else begin
          logic signed [23:0] want;
          want = expected_samples.pop_front();
          if (sample_out_o !== want) begin
            errors++;
            $error("sample_out: expected %0d actual %0d", want, sample_out_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cnt <= 0;
    else if (idle_cnt >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  task automatic write_reg(slhi_pkg::cfg_index_e idx, logic [17:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sender pauses until every expected sample is back
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic beat_t rand_beat();
    beat_t nb;
    case ($urandom_range(9))
      0: nb.smp = 24'sh7FFFFF;
      1: nb.smp = 24'sh800000;
      2: nb.smp = 24'($urandom_range(4000) - 2000);
      default: nb.smp = 24'($urandom);
    endcase
    if ($urandom_range(9) == 0) begin
      nb.f_start = 17'($urandom);
      nb.f_end = 17'($urandom);
    end else begin
      nb.f_start = 17'($urandom_range(96000));
      nb.f_end = 17'($urandom_range(96000));
    end
    return nb;
  endfunction

  initial begin
    beat_t nb;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part at reset config: extremes of sample and cutoffs
    pending_beats.push_back('{24'sh7FFFFF, 17'd1000, 17'd1000});
    pending_beats.push_back('{24'sh7FFFFF, 17'd0, 17'd96000});
    pending_beats.push_back('{24'sh800000, 17'd96000, 17'd0});
    pending_beats.push_back('{24'sh800000, 17'h1FFFF, 17'h1FFFF});
    pending_beats.push_back('{24'sh000000, 17'd0, 17'd0});
    pending_beats.push_back('{24'sh000001, 17'd24000, 17'd48000});
    pending_beats.push_back('{24'shFFFFFF, 17'd20, 17'd20000});
    pending_beats.push_back('{24'sh555555, 17'h0AAAA, 17'h15555});
    pending_beats.push_back('{24'shAAAAAA, 17'h15555, 17'h0AAAA});
    drain();

    // block shrinks below the current position: ramp clamps to its end, then restarts
    write_reg(slhi_pkg::CFG_BLOCK_LEN, 18'd3);
    for (int i = 0; i < 4; i++) pending_beats.push_back(rand_beat());
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(slhi_pkg::CFG_FILTER_MODE, 18'(PH_MODE[ph]));
      write_reg(slhi_pkg::CFG_SAMPLE_RATE, PH_FS[ph]);
      write_reg(slhi_pkg::CFG_BLOCK_LEN, 18'(PH_LEN[ph]));
      calm = (ph == 5);
      // a run of full-scale alternating samples drives the state to saturation
      if (ph == 3)
        for (int i = 0; i < 6; i++)
          pending_beats.push_back('{(i % 2) ? 24'sh800000 : 24'sh7FFFFF,
                                    17'd90000, 17'd1000});
      for (int i = 0; i < RAND_ITEMS / 12; i++) begin
        nb = rand_beat();
        pending_beats.push_back(nb);
      end
      drain();
    end
    calm = 1'b0;

    $display("covered %0d input beats, %0d output beats, %0d register writes",
             n_in, n_out, n_cfg);
    $display("all four modes, sample rates 0..262143, block lengths 0..8191");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
